// ----- rtl/broken_down_time_to_filetime_core_assert.svh -----
// Assertion macros shared by the calendar-to-tick-count RTL.
`ifndef BROKEN_DOWN_TIME_TO_FILETIME_CORE_ASSERT_SVH
`define BROKEN_DOWN_TIME_TO_FILETIME_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BDTF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BDTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bdtf_pkg.sv -----
// Package with the types, constants and month table of the tick-count converter.
`timescale 1ns / 1ps

package bdtf_pkg;

	// Days from 1601-01-01 to 1970-01-01, minus one (day of month starts at one),
	// minus 70 * 365 because the year is carried as an offset from 1900.
	localparam logic signed [20:0] DAY_BIAS = 21'sd109223;
	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
	localparam logic [5:0] SEC_PER_MIN = 6'd60;
	// Ticks of 100 ns in one second.
	localparam logic [23:0] TICKS_PER_SEC = 24'd10000000;
	// Reciprocals for the century and quad-century quotients.
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int RECIP_100_SHIFT = 19;
	localparam int RECIP_400_SHIFT = 21;
	// Rising edges from the accepting edge until done is seen high.
	localparam int ACCEPT_TO_DONE = 6;

	// One calendar word as held in the input register.
	typedef struct packed {
		logic       valid;
		logic [9:0] years_since_1900;
		logic [3:0] month_index;
		logic [4:0] day_of_month;
		logic [4:0] hour_of_day;
		logic [5:0] minute_of_hour;
		logic [5:0] second_of_minute;
		logic       daylight_saving;
	} item_t;

	// Day count since 1601 and second of day, handed to the scaling stages.
	typedef struct packed {
		logic               valid;
		logic               zero;
		logic [18:0]        day_count;
		logic signed [17:0] sec_of_day;
	} days_word_t;

	// Days before the first of each month in a common year.
	function automatic logic [8:0] cum_days(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/bdtf_days.sv -----
// Two pipeline stages that turn the calendar word into days since 1601 and second of day.
`timescale 1ns / 1ps

module bdtf_days import bdtf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	output days_word_t days_word
);

	// Stage 2: year offset, leap-day quotients, second of day.
	logic        valid_s2;
	logic        zero_s2;
	logic [10:0] year_s2;
	logic [3:0]  mon_s2;
	logic [4:0]  day_s2;
	logic signed [8:0]  quad_s2;
	logic [3:0]  cent_s2;
	logic [1:0]  qcent_s2;
	logic signed [17:0] tod_s2;

	logic        wrap;
	logic [10:0] year_c;
	logic [3:0]  mon_c;
	logic signed [11:0] from_1968;
	logic [11:0] mag_1968;
	logic [9:0]  quad_mag;
	logic signed [8:0]  quad_c;
	logic [10:0] from_1600;
	logic [23:0] cent_prod;
	logic [23:0] qcent_prod;
	logic signed [17:0] tod_c;
	logic        zero_c;

	always_comb begin
		wrap = item.month_index >= 4'd12;
		year_c = {1'b0, item.years_since_1900} + {10'b0, wrap};
		mon_c = wrap ? item.month_index - 4'd12 : item.month_index;
		// Quotient by four truncated toward zero, as the year may lie before 1968.
		from_1968 = $signed({1'b0, year_c}) - 12'sd68;
		mag_1968 = from_1968[11] ? 12'(-from_1968) : 12'(from_1968);
		quad_mag = mag_1968[11:2];
		quad_c = from_1968[11] ? -$signed({1'b0, quad_mag[7:0]}) : $signed({1'b0, quad_mag[7:0]});
		from_1600 = year_c + 11'd300;
		cent_prod = 24'(year_c) * 24'(RECIP_100);
		qcent_prod = 24'(from_1600) * 24'(RECIP_100);
		tod_c = $signed({1'b0, 17'(item.hour_of_day) * 17'(SEC_PER_HOUR)})
			+ $signed({6'b0, 12'(item.minute_of_hour) * 12'(SEC_PER_MIN)})
			+ $signed({12'b0, item.second_of_minute})
			- (item.daylight_saving ? $signed({6'b0, SEC_PER_HOUR}) : 18'sd0);
		zero_c = (item.years_since_1900 == '0) && (item.month_index == '0)
			&& (item.day_of_month == '0) && (item.hour_of_day == '0)
			&& (item.minute_of_hour == '0) && (item.second_of_minute == '0)
			&& !item.daylight_saving;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_s2 <= zero_c;
		year_s2 <= year_c;
		mon_s2 <= mon_c;
		day_s2 <= item.day_of_month;
		quad_s2 <= quad_c;
		cent_s2 <= cent_prod[RECIP_100_SHIFT+3:RECIP_100_SHIFT];
		qcent_s2 <= qcent_prod[RECIP_400_SHIFT+1:RECIP_400_SHIFT];
		tod_s2 <= tod_c;
	end

	// Stage 3: leap test and the day sum.
	logic        leap;
	logic        skip_day;
	logic [10:0] from_1600_s2;
	logic signed [20:0] day_sum;
	days_word_t  days_s3;

	always_comb begin
		from_1600_s2 = year_s2 + 11'd300;
		leap = (year_s2[1:0] == 2'b00)
			&& ((year_s2 != 11'(cent_s2) * 11'd100)
			|| (from_1600_s2 == 11'(11'(qcent_s2) * 11'd400)));
		skip_day = leap && (mon_s2 < 4'd2);
		day_sum = $signed({10'b0, year_s2}) * 21'sd365
			+ $signed({12'b0, cum_days(mon_s2)})
			+ 21'(quad_s2)
			- $signed({17'b0, cent_s2})
			+ $signed({19'b0, qcent_s2})
			- $signed({20'b0, skip_day})
			+ $signed({16'b0, day_s2})
			+ DAY_BIAS;
	end

	// The stage-three word is cleared whole by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			days_s3 <= '0;
		end else begin
			days_s3.valid <= valid_s2;
			days_s3.zero <= zero_s2;
			days_s3.day_count <= day_sum[18:0];
			days_s3.sec_of_day <= tod_s2;
		end
	end

	assign days_word = days_s3;

endmodule

// ----- rtl/bdtf_scale.sv -----
// Three pipeline stages that scale the day count to seconds and then to 100 ns ticks.
`timescale 1ns / 1ps

module bdtf_scale import bdtf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  days_word_t  days_word,
	output logic        done,
	output logic [61:0] tick_count
);

	// Stage 4: seconds since 1601.
	logic        valid_s4;
	logic        zero_s4;
	logic [35:0] secs_s4;
	logic signed [37:0] secs_sum;

	assign secs_sum = $signed({2'b0, 36'(36'(days_word.day_count) * 36'(SEC_PER_DAY))})
		+ 38'(days_word.sec_of_day);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= days_word.valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_s4 <= days_word.zero;
		secs_s4 <= secs_sum[35:0];
	end

	// Stage 5: two partial products of the seconds by ticks per second.
	logic        valid_s5;
	logic        zero_s5;
	logic [41:0] prod_lo_s5;
	logic [41:0] prod_hi_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		zero_s5 <= zero_s4;
		prod_lo_s5 <= 42'(secs_s4[17:0]) * 42'(TICKS_PER_SEC);
		prod_hi_s5 <= 42'(secs_s4[35:18]) * 42'(TICKS_PER_SEC);
	end

	// Stage 6: result register.
	logic [61:0] ticks_sum;

	assign ticks_sum = {2'b0, prod_hi_s5, 18'b0} + {20'b0, prod_lo_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		tick_count <= zero_s5 ? '0 : ticks_sum;
	end

endmodule

// ----- rtl/broken_down_time_to_filetime_core.sv -----
// Top level of the calendar time to 100 ns tick count converter.
//
//   Channel   Handshake          Payload
//   -------   ----------------   ------------------------------------------------
//   input     start / busy       years_since_1900, month_index, day_of_month,
//                                hour_of_day, minute_of_hour, second_of_minute,
//                                daylight_saving
//   result    done (strobe)      tick_count
//
// A word is taken at every rising edge at which start is high; busy stays low, so
// one word per cycle is sustained. Each result appears on done and tick_count
// for one cycle. It passes through the input register, the day count (two stages),
// the scaling to seconds, the split 36 by 24 bit multiply by ticks per second, and
// the result register. The receiver cannot stall, so no stage ever holds. Reset
// clears the valid bits of the pipeline, and the input register and the stage-three
// word whole; the other payload registers are left as they are.
`timescale 1ns / 1ps

module broken_down_time_to_filetime_core import bdtf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  years_since_1900,
	input  logic [3:0]  month_index,
	input  logic [4:0]  day_of_month,
	input  logic [4:0]  hour_of_day,
	input  logic [5:0]  minute_of_hour,
	input  logic [5:0]  second_of_minute,
	input  logic        daylight_saving,
	output logic        done,
	output logic [61:0] tick_count
);

`include "broken_down_time_to_filetime_core_assert.svh"

	// The pipeline never holds, so a new word is welcome in every cycle.
	assign busy = 1'b0;

	logic       accept;
	item_t      item_s1;
	days_word_t days_word;

	assign accept = start && !busy;

	// Input register: cleared whole by reset, loaded every cycle afterward.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1.valid <= accept;
			item_s1.years_since_1900 <= years_since_1900;
			item_s1.month_index <= month_index;
			item_s1.day_of_month <= day_of_month;
			item_s1.hour_of_day <= hour_of_day;
			item_s1.minute_of_hour <= minute_of_hour;
			item_s1.second_of_minute <= second_of_minute;
			item_s1.daylight_saving <= daylight_saving;
		end
	end

	// Day count since 1601 and second of day.
	bdtf_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_s1),
		.days_word (days_word)
	);

	// Scaling to seconds and ticks, and the result register.
	bdtf_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.days_word  (days_word),
		.done       (done),
		.tick_count (tick_count)
	);

	// Every strobe answers a word taken a fixed number of cycles earlier.
	`BDTF_ASSERT_IMPL(a_done_has_word, clk, arst_n, done, $past(accept, ACCEPT_TO_DONE), "result strobe without an accepted word")

	// Every accepted word is answered.
	`BDTF_ASSERT_IMPL(a_word_gets_done, clk, arst_n, accept, ##ACCEPT_TO_DONE done, "accepted word produced no result")

	// The largest count any field pattern can reach stays below 2^59.
	`BDTF_ASSERT_IMPL(a_count_range, clk, arst_n, done, tick_count[61:59] == 3'b000, "tick count beyond its reachable range")

	// The input register follows the handshake.
	`BDTF_ASSERT_NEXT(a_s1_loads, clk, arst_n, accept, item_s1.valid, "accepted word not loaded into the input register")

endmodule
